/* rtl/smac_pkg.sv */
// Package for the shadow memory access checker.
// Holds field widths, command and status codes, queue entry type and state encoding.
// No dependencies.
`default_nettype none

package smac_pkg;

	localparam int ADDR_W = 17;
	localparam int SIZE_W = 13;
	localparam int IDX_W  = 20;	// widest shadow word index supported
	localparam int WORD_W = 32;

	localparam int DEF_SHADOW_WORDS    = 4096;
	localparam int DEF_MAX_ALLOC_BYTES = 4096;

	localparam logic [WORD_W-1:0] POISON_WORD = 32'hffff_ffff;

	localparam logic [1:0] CMD_CHECK   = 2'd0;
	localparam logic [1:0] CMD_ALLOC   = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_RSVD    = 2'd3;	// no meaning, answered as a bad request

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ILLEGAL = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;

	typedef enum logic [1:0] {
		OP_CHECK,
		OP_ALLOC,
		OP_RELEASE,
		OP_BAD
	} op_t;

	// One classified request, as handed from front to back
	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [3:0]        size;      // check width, 1..8
		logic              is_store;
		logic [IDX_W-1:0]  w;         // block or access word
		logic [IDX_W-1:0]  wlo;       // leading redzone word
		logic [IDX_W-1:0]  wend;      // tail word (or trailing redzone)
		logic [IDX_W-1:0]  last;      // trailing redzone word
		logic [WORD_W-1:0] tail;      // encoded partial tail word
	} qentry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_CHK_EVAL,
		BK_ALLOC_WR,
		BK_REL_RD,
		BK_REL_EVAL,
		BK_RESP
	} bk_state_t;

endpackage

`default_nettype wire

/* rtl/smac_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module smac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/smac_front.sv */
// Front end: accepts request beats and classifies them into queue entries.
// Depends on smac_pkg.
`default_nettype none

module smac_front
	import smac_pkg::*;
#(
	parameter int SHADOW_WORDS    = DEF_SHADOW_WORDS,
	parameter int MAX_ALLOC_BYTES = DEF_MAX_ALLOC_BYTES
) (
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,	// addr[16:0], size[29:17], zero fill
	input  wire  [2:0]  s_tuser,	// cmd[1:0], is_store[2]
	input  q_stat_t     q_stat,
	input  wire         init_done,
	output logic        push,
	output qentry_t     push_entry
);

	localparam logic [31:0] WIN_BYTES = 32'(SHADOW_WORDS * 32);
	localparam logic [31:0] N_WORDS   = 32'(SHADOW_WORDS);
	localparam logic [31:0] MAX_ALLOC = 32'(MAX_ALLOC_BYTES);

	logic [1:0]        cmd;
	logic [ADDR_W-1:0] addr;
	logic [SIZE_W-1:0] size;
	logic [31:0]       w32;
	logic [31:0]       last32;
	logic [31:0]       wend32;
	logic              in_win;
	logic              aligned;
	logic [WORD_W-1:0] tail;
	logic [1:0]        g;
	logic [2:0]        part;

	assign cmd  = s_tuser[1:0];
	assign addr = s_tdata[ADDR_W-1:0];
	assign size = s_tdata[ADDR_W +: SIZE_W];

	// accept when the queue has room and the store is initialized
	assign s_tready = init_done && !q_stat.full;
	assign push     = s_tvalid && s_tready;

	// word span of an allocation
	assign w32     = 32'(addr[ADDR_W-1:5]);
	assign wend32  = w32 + 32'(size[SIZE_W-1:5]);
	assign last32  = wend32 + ((size[4:0] != 5'd0) ? 32'd1 : 32'd0);
	assign in_win  = 32'(addr) < WIN_BYTES;
	assign aligned = addr[4:0] == 5'd0;
	assign g       = size[4:3];
	assign part    = size[2:0];

	// encode the partial tail word
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			if (2'(b) < g) begin
				tail[b*8 +: 8] = 8'h00;
			end else if (2'(b) == g && part != 3'd0) begin
				tail[b*8 +: 8] = {5'd0, part};
			end else begin
				tail[b*8 +: 8] = 8'hff;
			end
		end
	end

	// classify
	always_comb begin
		push_entry          = '0;
		push_entry.addr     = addr;
		push_entry.size     = size[3:0];
		push_entry.is_store = s_tuser[2];
		push_entry.w        = w32[IDX_W-1:0];
		push_entry.wlo      = IDX_W'(w32 - 32'd1);
		push_entry.wend     = wend32[IDX_W-1:0];
		push_entry.last     = last32[IDX_W-1:0];
		push_entry.tail     = tail;
		push_entry.op       = OP_BAD;
		if (in_win) begin
			unique case (cmd)
				CMD_CHECK: begin
					if (size >= SIZE_W'(1) && size <= SIZE_W'(8)) push_entry.op = OP_CHECK;
				end
				CMD_ALLOC: begin
					if (aligned && 32'(size) <= MAX_ALLOC && w32 != 32'd0 && last32 < N_WORDS)
						push_entry.op = OP_ALLOC;
				end
				CMD_RELEASE: begin
					if (aligned) push_entry.op = OP_RELEASE;
				end
				default: push_entry.op = OP_BAD;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/smac_queue.sv */
// Two-entry queue of classified requests between front and back.
// Depends on smac_pkg.
`default_nettype none

module smac_queue
	import smac_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  wire      push,
	input  qentry_t  push_entry,
	input  wire      pop,
	output qentry_t  head,
	output q_stat_t  q_stat
);

	localparam int DEPTH = 2;

	qentry_t    ent_q [DEPTH];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign head         = ent_q[rp_q];
	assign q_stat.full  = cnt_q == 2'(DEPTH);
	assign q_stat.empty = cnt_q == 2'd0;

	// store payload
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_entry;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

/* rtl/smac_back.sv */
// Back end: clears the shadow store, carries out check, allocate and release,
// and holds the result register. Depends on smac_pkg and smac_ram.
`default_nettype none

module smac_back
	import smac_pkg::*;
#(
	parameter int SHADOW_WORDS = DEF_SHADOW_WORDS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  qentry_t     head,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        init_done,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,	// fault_addr[16:0], zero fill
	output logic [2:0]  m_tuser	// status[1:0], access_kind[2]
);

	localparam int AW = $clog2(SHADOW_WORDS);
	localparam logic [AW-1:0] TOP_IDX = AW'(SHADOW_WORDS - 1);

	bk_state_t         state_q;
	bk_state_t         state_nx;
	qentry_t           op_q;
	logic [AW-1:0]     cur_q;
	logic [1:0]        st_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [1:0]        out_st_q;
	logic              out_kind_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [WORD_W-1:0] rdata;
	logic              load_out;
	logic              slot_free;
	logic [7:0]        k;
	logic [3:0]        reach;
	logic [1:0]        chk_st;

	smac_ram #(.WIDTH(WORD_W), .DEPTH(SHADOW_WORDS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign slot_free = !out_valid_q || m_tready;
	assign init_done = state_q != BK_CLEAR;

	// evaluate the granule byte of a check
	assign k     = rdata[op_q.addr[4:3]*8 +: 8];
	assign reach = 4'(op_q.addr[2:0]) + op_q.size;
	always_comb begin
		if (k == 8'd0) begin
			chk_st = ST_OK;
		end else if (op_q.size == 4'd8 || k[7]) begin
			chk_st = ST_ILLEGAL;
		end else if (8'(reach) > k) begin
			chk_st = ST_ILLEGAL;
		end else begin
			chk_st = ST_OK;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_CLEAR: if (cur_q == TOP_IDX) state_nx = BK_IDLE;
			BK_IDLE: begin
				if (!q_stat.empty) begin
					unique case (head.op)
						OP_CHECK:   state_nx = BK_CHK_EVAL;
						OP_ALLOC:   state_nx = BK_ALLOC_WR;
						OP_RELEASE: state_nx = BK_REL_RD;
						default:    state_nx = BK_RESP;
					endcase
				end
			end
			BK_CHK_EVAL: state_nx = BK_RESP;
			BK_ALLOC_WR: if (cur_q == op_q.last[AW-1:0]) state_nx = BK_RESP;
			BK_REL_RD:   state_nx = BK_REL_EVAL;
			BK_REL_EVAL: begin
				if (rdata == POISON_WORD || cur_q == TOP_IDX) state_nx = BK_RESP;
				else state_nx = BK_REL_RD;
			end
			BK_RESP: if (slot_free) state_nx = BK_IDLE;
			default: state_nx = BK_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		we       = 1'b0;
		waddr    = cur_q;
		wdata    = POISON_WORD;
		re       = 1'b0;
		raddr    = cur_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				we    = 1'b1;
				wdata = '0;
			end
			BK_IDLE: begin
				pop   = !q_stat.empty;
				re    = !q_stat.empty && head.op == OP_CHECK;
				raddr = head.w[AW-1:0];
			end
			BK_ALLOC_WR: begin
				we = 1'b1;
				if (cur_q == op_q.wlo[AW-1:0] || cur_q == op_q.last[AW-1:0]) begin
					wdata = POISON_WORD;
				end else if (cur_q == op_q.wend[AW-1:0]) begin
					wdata = op_q.tail;
				end else begin
					wdata = '0;
				end
			end
			BK_REL_RD:   re = 1'b1;
			BK_REL_EVAL: we = rdata != POISON_WORD;
			BK_RESP:     load_out = slot_free;
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == BK_IDLE && pop) begin
				cur_q <= (head.op == OP_ALLOC) ? head.wlo[AW-1:0] : head.w[AW-1:0];
			end else if (state_q == BK_CLEAR || state_q == BK_ALLOC_WR ||
			             state_q == BK_REL_EVAL) begin
				cur_q <= cur_q + AW'(1);
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// op and result payload
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && pop) begin
			op_q <= head;
			st_q <= (head.op == OP_BAD) ? ST_BAD : ST_OK;
		end else if (state_q == BK_CHK_EVAL) begin
			st_q <= chk_st;
		end
		if (load_out) begin
			out_addr_q <= op_q.addr;
			out_st_q   <= st_q;
			out_kind_q <= op_q.is_store;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_addr_q};
	assign m_tuser  = {out_kind_q, out_st_q};

	// no request is taken while the store is being cleared
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CLEAR |-> !pop) else $error("pop during clear");
	// a check never writes the store
	a_chk_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CHK_EVAL |-> !we) else $error("write during check");
	// a result is loaded only into a free slot
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || m_tready)) else $error("result overrun");
	// after a result the back end is idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> state_q == BK_IDLE && m_tvalid) else $error("bad resp exit");

endmodule

`default_nettype wire

/* rtl/shadow_memory_access_checker_top.sv */
// Top level of the shadow memory access checker: front, request queue, back end.
// Depends on smac_pkg, smac_front, smac_queue, smac_back.
//
//  channel | dir | tdata                          | tuser
//  s_*     | in  | addr[16:0], size[29:17]        | cmd[1:0], is_store[2]
//  m_*     | out | fault_addr[16:0]               | status[1:0], access_kind[2]
//
// A check in the back end: queue pop with registered RAM read, evaluation, result.
// Allocate writes one word a cycle on the single RAM port, leading to trailing redzone;
// release walks the words in turn, each read, then compared and written.
// After reset the store is cleared one word a cycle, with s_tready low.
// The two-entry queue and the output register let either side stall independently.
`default_nettype none

module shadow_memory_access_checker_top
	import smac_pkg::*;
#(
	parameter int SHADOW_WORDS    = DEF_SHADOW_WORDS,
	parameter int MAX_ALLOC_BYTES = DEF_MAX_ALLOC_BYTES
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,	// addr[16:0], size[29:17], zero fill
	input  wire  [2:0]  s_tuser,	// cmd[1:0], is_store[2]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,	// fault_addr[16:0], zero fill
	output logic [2:0]  m_tuser	// status[1:0], access_kind[2]
);

	q_stat_t q_stat;
	qentry_t push_entry;
	qentry_t head;
	logic    push;
	logic    pop;
	logic    init_done;

	smac_front #(
		.SHADOW_WORDS    (SHADOW_WORDS),
		.MAX_ALLOC_BYTES (MAX_ALLOC_BYTES)
	) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_stat     (q_stat),
		.init_done  (init_done),
		.push       (push),
		.push_entry (push_entry)
	);

	smac_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	smac_back #(.SHADOW_WORDS(SHADOW_WORDS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.init_done (init_done),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire
